### rtl/gtu_pkg.sv
// Shared types, constants and lookup functions for the GNSS time to UTC date unit.
// No dependencies; every other file of the unit imports this package.
`default_nettype none

package gtu_pkg;

  // Time constants: day and week lengths in milliseconds, four-year cycle length in days.
  localparam logic [26:0] MS_PER_DAY   = 27'd86400000;
  localparam logic [30:0] MS_PER_WEEK  = 31'd604800000;
  localparam int unsigned CYCLE_DAYS   = 1461;

  // Pipeline depth: front end stages and date/time split stages.
  localparam int unsigned FRONT_STAGES = 5;
  localparam int unsigned SPLIT_STAGES = 4;
  localparam int unsigned STAGES       = FRONT_STAGES + SPLIT_STAGES;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEAP_ENABLE  = 3'd0;
  localparam logic [2:0] REG_PARAMS_VALID = 3'd1;
  localparam logic [2:0] REG_SECONDS_NOW  = 3'd2;
  localparam logic [2:0] REG_SECONDS_FUT  = 3'd3;
  localparam logic [2:0] REG_EVENT_WEEK   = 3'd4;
  localparam logic [2:0] REG_EVENT_DAY    = 3'd5;

  // Leap second configuration as seen by the front end.
  typedef struct packed {
    logic        enable;
    logic        params_valid;
    logic [7:0]  seconds_now;
    logic [7:0]  seconds_future;
    logic [12:0] event_week;
    logic [2:0]  event_day;
  } leap_cfg_t;

  // First day of each month within a non-leap year.
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Millisecond of week, biased by one week as in the front end, at which the day after the event day begins.
  function automatic logic [30:0] leap_threshold(input logic [2:0] event_day);
    logic [3:0] k;
    k = {1'b0, event_day} + 4'd8;
    return 31'(k) * 31'(MS_PER_DAY);
  endfunction

endpackage

`default_nettype wire

### rtl/gnss_time_to_utc_date_unit.sv
// GNSS timestamp to UTC calendar date: top level with configuration registers.
// Depends on gtu_pkg, gtu_front, gtu_date and gtu_time.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one timestamp per item: mode
//    selects GPS week time or GLONASS four-year time in Moscow time.
//  - Output channel (out_valid/out_ready) carries one UTC date and time of
//    day per item, in input order.
//  - The APB port holds the leap second settings; write them only while no
//    item is in flight. pready is always high.
//  - Items pass from the accepting edge to out_valid through nine
//    register stages: five front end stages (leap correction, day reduction)
//    and four split stages.
//  - Throughput is one item per cycle while out_ready is high; all stages load.
//  - Each stage holds its item until the next stage can take it, so when
//    the receiver stalls the pipeline fills its empty slots and keeps
//    accepting items until every stage is occupied.
//  - Reset empties the pipeline, holds in_ready low and loads the leap
//    registers with their defaults: correction enabled, parameters invalid
//    (18 seconds).
`default_nettype none

module gnss_time_to_utc_date_unit import gtu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [12:0] gps_week,
  input  wire logic [29:0] week_ms,
  input  wire logic [4:0]  glo_period,
  input  wire logic [10:0] glo_day,
  input  wire logic [26:0] glo_day_ms,
  // Output channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second,
  output logic [9:0]       millisecond,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;
  leap_cfg_t         cfg;
  logic              wr;
  logic [15:0]       days;
  logic [26:0]       day_ms;

  // Configuration registers.
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b1;
      cfg.params_valid   <= 1'b0;
      cfg.seconds_now    <= 8'd18;
      cfg.seconds_future <= 8'd18;
      cfg.event_week     <= 13'd0;
      cfg.event_day      <= 3'd1;
    end else if (wr) begin
      case (paddr[4:2])
        REG_LEAP_ENABLE:  cfg.enable         <= pwdata[0];
        REG_PARAMS_VALID: cfg.params_valid   <= pwdata[0];
        REG_SECONDS_NOW:  cfg.seconds_now    <= pwdata[7:0];
        REG_SECONDS_FUT:  cfg.seconds_future <= pwdata[7:0];
        REG_EVENT_WEEK:   cfg.event_week     <= pwdata[12:0];
        REG_EVENT_DAY:    cfg.event_day      <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[4:2])
      REG_LEAP_ENABLE:  prdata = {31'd0, cfg.enable};
      REG_PARAMS_VALID: prdata = {31'd0, cfg.params_valid};
      REG_SECONDS_NOW:  prdata = {24'd0, cfg.seconds_now};
      REG_SECONDS_FUT:  prdata = {24'd0, cfg.seconds_future};
      REG_EVENT_WEEK:   prdata = {19'd0, cfg.event_week};
      REG_EVENT_DAY:    prdata = {29'd0, cfg.event_day};
      default:          prdata = 32'd0;
    endcase
  end

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0] && !rst;
  assign out_valid = v[STAGES-1];

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Datapath.
  gtu_front u_front (
    .clk        (clk),
    .en         (en[FRONT_STAGES-1:0]),
    .cfg        (cfg),
    .mode       (mode),
    .gps_week   (gps_week),
    .week_ms    (week_ms),
    .glo_period (glo_period),
    .glo_day    (glo_day),
    .glo_day_ms (glo_day_ms),
    .days       (days),
    .day_ms     (day_ms)
  );

  gtu_date u_date (
    .clk   (clk),
    .en    (en[STAGES-1:FRONT_STAGES]),
    .days  (days),
    .year  (year),
    .month (month),
    .day   (day)
  );

  gtu_time u_time (
    .clk         (clk),
    .en          (en[STAGES-1:FRONT_STAGES]),
    .day_ms      (day_ms),
    .hour        (hour),
    .minute      (minute),
    .second      (second),
    .millisecond (millisecond)
  );

  // A ready receiver never blocks the input.
  a_ready_passes: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while receiver ready");

  // An accepted item occupies the first stage on the next cycle.
  a_item_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted item lost at first stage");

  // Delivered fields stay in their calendar ranges.
  a_fields_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 && day <= 5'd31 &&
                   hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 &&
                   millisecond <= 10'd999))
    else $error("output field out of range");

  // A write to the enable register takes effect on the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (wr && paddr[4:2] == REG_LEAP_ENABLE) |=> (cfg.enable == $past(pwdata[0])))
    else $error("leap enable write lost");

endmodule

`default_nettype wire

### rtl/gtu_front.sv
// Front end: reduces a GPS or GLONASS timestamp to a biased day count and a ms of day.
// Depends on gtu_pkg. Five register stages, each loaded by its own enable.
`default_nettype none

module gtu_front import gtu_pkg::*; (
  input  wire logic                     clk,
  input  wire logic [FRONT_STAGES-1:0]  en,
  input  wire leap_cfg_t                cfg,
  input  wire logic                     mode,
  input  wire logic [12:0]              gps_week,
  input  wire logic [29:0]              week_ms,
  input  wire logic [4:0]               glo_period,
  input  wire logic [10:0]              glo_day,
  input  wire logic [26:0]              glo_day_ms,
  output logic      [15:0]              days,
  output logic      [26:0]              day_ms
);

  // Stage 1 registers.
  logic               mode1;
  logic [12:0]        week1;
  logic [30:0]        ms1;
  logic signed [18:0] diff1;
  logic               gt1;
  logic               eq1;
  logic [30:0]        thr1;
  logic [15:0]        ub1;
  logic signed [27:0] msg1;

  // Stage 2 registers.
  logic               mode2;
  logic [12:0]        week2;
  logic [30:0]        msw2;
  logic [15:0]        uw2;

  // Stage 3 registers.
  logic               mode3;
  logic [12:0]        week3;
  logic [30:0]        msw3;
  logic [15:0]        uw3;
  logic [4:0]         est3;

  // Stage 4 registers.
  logic [27:0]        ms4;
  logic [15:0]        u4;

  // Combinational values.
  logic signed [7:0]  now_s;
  logic signed [7:0]  fut_s;
  logic signed [17:0] leap_ms;
  logic signed [31:0] ms1_next;
  logic signed [18:0] diff_next;
  logic               use_fut;
  logic [15:0]        ub_next;
  logic signed [27:0] msg_next;
  logic               apply_fut;
  logic [30:0]        ms2_gps;
  logic [26:0]        gms;
  logic [15:0]        gu;
  logic [24:0]        est_prod;
  logic [27:0]        rem_gps;
  logic [15:0]        u_gps;

  // Stage 1: current leap offset, future offset and GLONASS day count.
  always_comb begin
    now_s = $signed(cfg.seconds_now);
    fut_s = $signed(cfg.seconds_future);
    if (!cfg.enable) begin
      leap_ms = 18'sd0;
    end else if (!cfg.params_valid) begin
      leap_ms = 18'sd18000;
    end else begin
      leap_ms = 18'(now_s * 18'sd1000);
    end
    ms1_next  = $signed({2'b00, week_ms}) + $signed({1'b0, MS_PER_WEEK}) - 32'(leap_ms);
    diff_next = (19'(fut_s) - 19'(now_s)) * 19'sd1000;
    use_fut   = cfg.enable & cfg.params_valid & (cfg.seconds_now != cfg.seconds_future);
    ub_next   = 16'(glo_period) * 16'd1461 + 16'(glo_day) + 16'd5843;
    msg_next  = $signed({1'b0, glo_day_ms}) - 28'sd10800000;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mode1 <= mode;
      week1 <= gps_week;
      ms1   <= ms1_next[30:0];
      diff1 <= diff_next;
      gt1   <= use_fut & (gps_week > cfg.event_week);
      eq1   <= use_fut & (gps_week == cfg.event_week);
      thr1  <= leap_threshold(cfg.event_day);
      ub1   <= ub_next;
      msg1  <= msg_next;
    end
  end

  // Stage 2: future leap correction in GPS mode, Moscow day wrap in GLONASS mode.
  always_comb begin
    apply_fut = gt1 | (eq1 & (ms1 >= thr1));
    if (apply_fut) begin
      ms2_gps = 31'($signed({1'b0, ms1}) - 32'(diff1));
    end else begin
      ms2_gps = ms1;
    end
    if (msg1 < 28'sd0) begin
      gms = 27'(msg1 + $signed({1'b0, MS_PER_DAY}));
      gu  = ub1 - 16'd1;
    end else if (msg1 >= $signed({1'b0, MS_PER_DAY})) begin
      gms = 27'(msg1 - $signed({1'b0, MS_PER_DAY}));
      gu  = ub1 + 16'd1;
    end else begin
      gms = msg1[26:0];
      gu  = ub1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mode2 <= mode1;
      week2 <= week1;
      msw2  <= mode1 ? {4'b0000, gms} : ms2_gps;
      uw2   <= gu;
    end
  end

  // Stage 3: day estimate from the top bits, never above the true quotient.
  assign est_prod = 25'(msw2[30:16]) * 25'd795;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mode3 <= mode2;
      week3 <= week2;
      msw3  <= msw2;
      uw3   <= uw2;
      est3  <= est_prod[24:20];
    end
  end

  // Stage 4: remainder of the estimate and the biased GPS day count.
  always_comb begin
    rem_gps = 28'(msw3 - 31'(est3) * 31'(MS_PER_DAY));
    u_gps   = 16'(week3) * 16'd7 + 16'd1459 + 16'(est3);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ms4 <= mode3 ? msw3[27:0] : rem_gps;
      u4  <= mode3 ? uw3 : u_gps;
    end
  end

  // Stage 5: final correction when the estimate fell one day short.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      if (ms4 >= {1'b0, MS_PER_DAY}) begin
        day_ms <= 27'(ms4 - {1'b0, MS_PER_DAY});
        days   <= u4 + 16'd1;
      end else begin
        day_ms <= ms4[26:0];
        days   <= u4;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/gtu_date.sv
// Date split: biased day count to year, month and day of month over four stages.
// Depends on gtu_pkg for the month table and cycle length.
`default_nettype none

module gtu_date import gtu_pkg::*; (
  input  wire logic                     clk,
  input  wire logic [SPLIT_STAGES-1:0]  en,
  input  wire logic [15:0]              days,
  output logic      [11:0]              year,
  output logic      [3:0]               month,
  output logic      [4:0]               day
);

  logic [5:0]  cyc1;
  logic [15:0] u1;
  logic [10:0] d2;
  logic [11:0] yr2;
  logic [8:0]  doy3;
  logic [11:0] yr3;
  logic        leap3;

  logic [31:0] cyc_prod;
  logic [8:0]  doy_next;
  logic [11:0] yr_next;
  logic        leap_next;
  logic [3:0]  month_next;
  logic [4:0]  mday_next;

  // Stage 1: four-year cycle by exact reciprocal multiplication.
  assign cyc_prod = 32'(days) * 32'd45934;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cyc1 <= cyc_prod[31:26];
      u1   <= days;
    end
  end

  // Stage 2: day within the cycle and base year of the cycle.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      d2  <= 11'(u1 - 16'(cyc1) * 16'(CYCLE_DAYS));
      yr2 <= 12'd1976 + (12'(cyc1) << 2);
    end
  end

  // Stage 3: year within the cycle; the leap year comes first.
  always_comb begin
    doy_next  = 9'(d2);
    yr_next   = yr2;
    leap_next = 1'b0;
    if (d2 >= 11'd1096) begin
      doy_next = 9'(d2 - 11'd1096);
      yr_next  = yr2 + 12'd3;
    end else if (d2 >= 11'd731) begin
      doy_next = 9'(d2 - 11'd731);
      yr_next  = yr2 + 12'd2;
    end else if (d2 >= 11'd366) begin
      doy_next = 9'(d2 - 11'd366);
      yr_next  = yr2 + 12'd1;
    end else if (d2 >= 11'd60) begin
      doy_next = 9'(d2 - 11'd1);
    end else if (d2 == 11'd59) begin
      leap_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      doy3  <= doy_next;
      yr3   <= yr_next;
      leap3 <= leap_next;
    end
  end

  // Stage 4: month by parallel compares against the month table.
  always_comb begin
    month_next = 4'd12;
    for (int i = 11; i >= 1; i--) begin
      if (doy3 < month_start(4'(i))) begin
        month_next = 4'(i);
      end
    end
    mday_next = 5'(doy3 - month_start(month_next - 4'd1) + 9'd1);
    if (leap3) begin
      month_next = 4'd2;
      mday_next  = 5'd29;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      year  <= yr3;
      month <= month_next;
      day   <= mday_next;
    end
  end

endmodule

`default_nettype wire

### rtl/gtu_time.sv
// Time split: millisecond of day to hour, minute, second and millisecond.
// Depends on gtu_pkg; four stages to line up with the date split.
`default_nettype none

module gtu_time import gtu_pkg::*; (
  input  wire logic                     clk,
  input  wire logic [SPLIT_STAGES-1:0]  en,
  input  wire logic [26:0]              day_ms,
  output logic      [4:0]               hour,
  output logic      [5:0]               minute,
  output logic      [5:0]               second,
  output logic      [9:0]               millisecond
);

  logic [16:0] sec1;
  logic [26:0] ms1;
  logic [4:0]  hour2;
  logic [10:0] mtot2;
  logic [16:0] sec2;
  logic [9:0]  msec2;
  logic [4:0]  hour3;
  logic [5:0]  minute3;
  logic [5:0]  second3;
  logic [9:0]  msec3;

  logic [54:0] sec_prod;
  logic [34:0] hour_prod;
  logic [34:0] min_prod;

  // Stage 1: second of day by exact reciprocal of 1000.
  assign sec_prod = 55'(day_ms) * 55'd137438954;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec1 <= sec_prod[53:37];
      ms1  <= day_ms;
    end
  end

  // Stage 2: millisecond remainder, hour and minute of day.
  assign hour_prod = 35'(sec1) * 35'd149131;
  assign min_prod  = 35'(sec1) * 35'd139811;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      msec2 <= 10'(ms1 - 27'(sec1) * 27'd1000);
      hour2 <= hour_prod[33:29];
      mtot2 <= min_prod[33:23];
      sec2  <= sec1;
    end
  end

  // Stage 3: minute of hour and second of minute.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      hour3   <= hour2;
      minute3 <= 6'(mtot2 - 11'(hour2) * 11'd60);
      second3 <= 6'(sec2 - 17'(mtot2) * 17'd60);
      msec3   <= msec2;
    end
  end

  // Stage 4: output registers, level with the date split.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      hour        <= hour3;
      minute      <= minute3;
      second      <= second3;
      millisecond <= msec3;
    end
  end

endmodule

`default_nettype wire
